FILE: rtl/core/polar_rect_converter_unit_macros.svh
// assertion macros for the polar/rectangular converter
// expects clk and rst_n in the scope where a macro is used
`ifndef POLAR_RECT_CONVERTER_UNIT_MACROS_SVH
`define POLAR_RECT_CONVERTER_UNIT_MACROS_SVH

// consequent holds in the same cycle as the antecedent
`define PRC_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent holds in the cycle after the antecedent
`define PRC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/core/prc_pkg.sv
`timescale 1ns / 1ps
// shared types, constants and the cordic arctangent table
// used by every module of the polar/rectangular converter
package prc_pkg;

    localparam int COORD_WIDTH_DEF = 16;
    localparam int ITERATIONS_DEF  = 16;
    localparam int ANGLE_WIDTH     = 16;
    // angle accumulator: 32-bit turn fraction plus a sign guard bit
    localparam int ZW              = 33;
    // datapath headroom above the coordinate width (16 fraction bits plus growth)
    localparam int GUARD_BITS      = 20;
    localparam int FRAC_BITS       = 16;
    // 1/K of the cordic in q30
    localparam logic [29:0] INV_GAIN_Q30 = 30'd652032874;

    typedef enum logic
    {
        CMD_TO_POLAR = 1'b0,
        CMD_TO_RECT  = 1'b1
    } prc_cmd_t;

    typedef struct packed
    {
        logic     valid;
        prc_cmd_t cmd;
        logic     origin;
    } prc_ctrl_t;

    typedef struct packed
    {
        logic skid_valid;
    } prc_stat_t;

    // atan(2^-i) in units of 2^-32 turn
    function automatic logic [31:0] atan_at(input int unsigned idx);
        logic [31:0] v;
        case (idx)
            0:       v = 32'h20000000;
            1:       v = 32'h12E4051E;
            2:       v = 32'h09FB385B;
            3:       v = 32'h051111D4;
            4:       v = 32'h028B0D43;
            5:       v = 32'h0145D7E1;
            6:       v = 32'h00A2F61E;
            7:       v = 32'h00517C55;
            8:       v = 32'h0028BE53;
            9:       v = 32'h00145F2F;
            10:      v = 32'h000A2F98;
            11:      v = 32'h000517CC;
            12:      v = 32'h00028BE6;
            13:      v = 32'h000145F3;
            14:      v = 32'h0000A2FA;
            15:      v = 32'h0000517D;
            16:      v = 32'h000028BE;
            17:      v = 32'h0000145F;
            18:      v = 32'h00000A30;
            19:      v = 32'h00000518;
            20:      v = 32'h0000028C;
            21:      v = 32'h00000146;
            22:      v = 32'h000000A3;
            23:      v = 32'h00000051;
            24:      v = 32'h00000029;
            25:      v = 32'h00000014;
            26:      v = 32'h0000000A;
            27:      v = 32'h00000005;
            28:      v = 32'h00000003;
            29:      v = 32'h00000001;
            30:      v = 32'h00000001;
            default: v = 32'h00000000;
        endcase
        return v;
    endfunction

endpackage

FILE: rtl/core/polar_rect_converter_unit.sv
`timescale 1ns / 1ps
// polar_rect_converter_unit: rectangular <-> polar conversion
// Input stream s_*: tuser selects the direction (0 rectangular to polar,
// 1 polar to rectangular); tdata carries x, y, radius, angle and height.
// Output stream m_*: one result transaction per input transaction, in order,
// with x, y, radius, angle (65536 = one turn) and height.
// Radius is an integer square root rounded to nearest, angle and x/y come
// from a cordic with ITERATIONS micro-rotations; x/y saturate.
// Pipeline: two conditioning stages, one cell per cordic rotation /
// square-root digit, one output register.
// Throughput: one transaction per cycle while the chain is not stalled;
// every cell hands its item on in each cycle the chain advances.
// Stall: the chain and s_tready hold only while the skid buffer behind a
// stalled output register is full, so one result can wait while a new item
// is still taken.
// Reset: rst_n clears all valid bits; no results are pending afterwards.
`include "polar_rect_converter_unit_macros.svh"

module polar_rect_converter_unit import prc_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF,
    parameter int ITERATIONS  = ITERATIONS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // coord_x, coord_y, radius, angle, height (zero padded to bytes)
    input  logic [((4*COORD_WIDTH+ANGLE_WIDTH+7)/8)*8-1:0] s_tdata,
    // cmd
    input  logic                  s_tuser,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // out_x, out_y, out_radius, out_angle, out_height (zero padded to bytes)
    output logic [((4*COORD_WIDTH+ANGLE_WIDTH+7)/8)*8-1:0] m_tdata
);

    localparam int CW    = COORD_WIDTH;
    localparam int DW    = COORD_WIDTH + GUARD_BITS;
    localparam int TW    = ((4 * COORD_WIDTH + ANGLE_WIDTH + 7) / 8) * 8;
    localparam int NCELL = (COORD_WIDTH > ITERATIONS) ? COORD_WIDTH : ITERATIONS;

    logic      pipe_en;
    prc_stat_t stat;

    prc_ctrl_t            ctrl_c   [0:NCELL];
    logic signed [DW-1:0] x_c      [0:NCELL];
    logic signed [DW-1:0] y_c      [0:NCELL];
    logic signed [ZW-1:0] z_c      [0:NCELL];
    logic [2*CW-1:0]      sq_c     [0:NCELL];
    logic [CW-1:0]        root_c   [0:NCELL];
    logic [CW+1:0]        rem_c    [0:NCELL];
    logic signed [CW-1:0] height_c [0:NCELL];

    // the chain only stops when the skid buffer is occupied
    assign pipe_en  = !stat.skid_valid;
    assign s_tready = pipe_en;

    // input conditioning
    prc_prep #(
        .CW (CW),
        .DW (DW)
    ) u_prep (
        .clk        (clk),
        .rst_n      (rst_n),
        .pipe_en    (pipe_en),
        .in_valid   (s_tvalid),
        .cmd        (prc_cmd_t'(s_tuser)),
        .coord_x    (s_tdata[CW-1:0]),
        .coord_y    (s_tdata[2*CW-1:CW]),
        .radius     (s_tdata[3*CW-1:2*CW]),
        .angle      (s_tdata[3*CW+ANGLE_WIDTH-1:3*CW]),
        .height     (s_tdata[4*CW+ANGLE_WIDTH-1:3*CW+ANGLE_WIDTH]),
        .ctrl_out   (ctrl_c[0]),
        .x_out      (x_c[0]),
        .y_out      (y_c[0]),
        .z_out      (z_c[0]),
        .sq_out     (sq_c[0]),
        .height_out (height_c[0])
    );

    assign root_c[0] = '0;
    assign rem_c[0]  = '0;

    // chain of rotation / root cells
    for (genvar i = 0; i < NCELL; i++)
    begin : g_cell
        prc_cell #(
            .CW        (CW),
            .DW        (DW),
            .IDX       (i),
            .ROTATE    (i < ITERATIONS),
            .ROOT_STEP (i < COORD_WIDTH)
        ) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .pipe_en    (pipe_en),
            .ctrl_in    (ctrl_c[i]),
            .x_in       (x_c[i]),
            .y_in       (y_c[i]),
            .z_in       (z_c[i]),
            .sq_in      (sq_c[i]),
            .root_in    (root_c[i]),
            .rem_in     (rem_c[i]),
            .height_in  (height_c[i]),
            .ctrl_out   (ctrl_c[i+1]),
            .x_out      (x_c[i+1]),
            .y_out      (y_c[i+1]),
            .z_out      (z_c[i+1]),
            .sq_out     (sq_c[i+1]),
            .root_out   (root_c[i+1]),
            .rem_out    (rem_c[i+1]),
            .height_out (height_c[i+1])
        );
    end

    // rounding, saturation and output buffering
    prc_post #(
        .CW (CW),
        .DW (DW),
        .TW (TW)
    ) u_post (
        .clk       (clk),
        .rst_n     (rst_n),
        .pipe_en   (pipe_en),
        .ctrl_in   (ctrl_c[NCELL]),
        .x_in      (x_c[NCELL]),
        .y_in      (y_c[NCELL]),
        .z_in      (z_c[NCELL]),
        .root_in   (root_c[NCELL]),
        .rem_in    (rem_c[NCELL]),
        .height_in (height_c[NCELL]),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .stat      (stat)
    );

    // checks
    `PRC_ASSERT_SAME(a_skid_behind_out, stat.skid_valid, m_tvalid, "skid full without output")
    `PRC_ASSERT_SAME(a_skid_fill_on_stall, $rose(stat.skid_valid), $past(m_tvalid && !m_tready), "skid filled without stall")
    `PRC_ASSERT_NEXT(a_chain_holds, !pipe_en, $stable(ctrl_c[NCELL].valid), "chain moved while stalled")

endmodule

FILE: rtl/core/prc_prep.sv
`timescale 1ns / 1ps
// input conditioning: squares, gain pre-scale, quadrant fold, cordic seed
// two register stages; depends on prc_pkg
module prc_prep import prc_pkg::*;
#(
    parameter int CW = COORD_WIDTH_DEF,
    parameter int DW = COORD_WIDTH_DEF + GUARD_BITS
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   pipe_en,
    input  logic                   in_valid,
    input  prc_cmd_t               cmd,
    input  logic signed [CW-1:0]   coord_x,
    input  logic signed [CW-1:0]   coord_y,
    input  logic [CW-1:0]          radius,
    input  logic [ANGLE_WIDTH-1:0] angle,
    input  logic signed [CW-1:0]   height,
    output prc_ctrl_t              ctrl_out,
    output logic signed [DW-1:0]   x_out,
    output logic signed [DW-1:0]   y_out,
    output logic signed [ZW-1:0]   z_out,
    output logic [2*CW-1:0]        sq_out,
    output logic signed [CW-1:0]   height_out
);

    // stage a registers
    prc_ctrl_t              ctrl_a_reg,   ctrl_a_next;
    logic [2*CW-1:0]        sx2_a_reg,    sx2_a_next;
    logic [2*CW-1:0]        sy2_a_reg,    sy2_a_next;
    logic signed [CW:0]     ax_a_reg,     ax_a_next;
    logic signed [CW:0]     ay_a_reg,     ay_a_next;
    logic                   half_a_reg,   half_a_next;
    logic [CW+29:0]         rg_a_reg,     rg_a_next;
    logic                   fold_a_reg,   fold_a_next;
    logic [31:0]            za_a_reg,     za_a_next;
    logic signed [CW-1:0]   height_a_reg;

    // stage b registers
    prc_ctrl_t              ctrl_b_reg,   ctrl_b_next;
    logic signed [DW-1:0]   x_b_reg,      x_b_next;
    logic signed [DW-1:0]   y_b_reg,      y_b_next;
    logic signed [ZW-1:0]   z_b_reg,      z_b_next;
    logic [2*CW-1:0]        sq_b_reg,     sq_b_next;
    logic signed [CW-1:0]   height_b_reg;

    logic signed [CW:0]     x_ext;
    logic signed [CW:0]     y_ext;
    logic signed [2*CW-1:0] px;
    logic signed [2*CW-1:0] py;
    logic [31:0]            a_full;
    logic signed [DW-1:0]   xg;

    // stage a: squares, gain product, negate for left half plane, fold angle
    always_comb
    begin
        x_ext           = {coord_x[CW-1], coord_x};
        y_ext           = {coord_y[CW-1], coord_y};
        a_full          = {angle, 16'h0000};
        ctrl_a_next.valid  = in_valid;
        ctrl_a_next.cmd    = cmd;
        ctrl_a_next.origin = (coord_x == '0) && (coord_y == '0);
        // full-width signed products
        px              = coord_x * coord_x;
        py              = coord_y * coord_y;
        sx2_a_next      = $unsigned(px);
        sy2_a_next      = $unsigned(py);
        half_a_next     = coord_x[CW-1];
        ax_a_next       = half_a_next ? -x_ext : x_ext;
        ay_a_next       = half_a_next ? -y_ext : y_ext;
        rg_a_next       = radius * INV_GAIN_Q30;
        fold_a_next     = (a_full[31:30] == 2'b01) || (a_full[31:30] == 2'b10);
        za_a_next       = fold_a_next ? {~a_full[31], a_full[30:0]} : a_full;
    end

    // stage b: sum of squares and cordic start vector
    always_comb
    begin
        xg          = {{(DW-CW-16){1'b0}}, rg_a_reg[CW+29:14]};
        ctrl_b_next = ctrl_a_reg;
        sq_b_next   = sx2_a_reg + sy2_a_reg;
        case (ctrl_a_reg.cmd)
            CMD_TO_RECT:
            begin
                x_b_next = fold_a_reg ? -xg : xg;
                y_b_next = '0;
                z_b_next = {za_a_reg[31], za_a_reg};
            end
            default:
            begin
                x_b_next = {{(DW-CW-17){ax_a_reg[CW]}}, ax_a_reg, 16'h0000};
                y_b_next = {{(DW-CW-17){ay_a_reg[CW]}}, ay_a_reg, 16'h0000};
                z_b_next = {1'b0, half_a_reg, 31'h0};
            end
        endcase
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctrl_a_reg <= '0;
            ctrl_b_reg <= '0;
        end
        else if (pipe_en)
        begin
            ctrl_a_reg <= ctrl_a_next;
            ctrl_b_reg <= ctrl_b_next;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            sx2_a_reg    <= sx2_a_next;
            sy2_a_reg    <= sy2_a_next;
            ax_a_reg     <= ax_a_next;
            ay_a_reg     <= ay_a_next;
            half_a_reg   <= half_a_next;
            rg_a_reg     <= rg_a_next;
            fold_a_reg   <= fold_a_next;
            za_a_reg     <= za_a_next;
            height_a_reg <= height;
            x_b_reg      <= x_b_next;
            y_b_reg      <= y_b_next;
            z_b_reg      <= z_b_next;
            sq_b_reg     <= sq_b_next;
            height_b_reg <= height_a_reg;
        end
    end

    assign ctrl_out   = ctrl_b_reg;
    assign x_out      = x_b_reg;
    assign y_out      = y_b_reg;
    assign z_out      = z_b_reg;
    assign sq_out     = sq_b_reg;
    assign height_out = height_b_reg;

endmodule

FILE: rtl/core/prc_cell.sv
`timescale 1ns / 1ps
// one pipeline cell: a cordic micro-rotation and/or square-root digit step
// depends on prc_pkg for the arctangent table and control types
module prc_cell import prc_pkg::*;
#(
    parameter int CW        = COORD_WIDTH_DEF,
    parameter int DW        = COORD_WIDTH_DEF + GUARD_BITS,
    parameter int IDX       = 0,
    parameter bit ROTATE    = 1'b1,
    parameter bit ROOT_STEP = 1'b1
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 pipe_en,
    input  prc_ctrl_t            ctrl_in,
    input  logic signed [DW-1:0] x_in,
    input  logic signed [DW-1:0] y_in,
    input  logic signed [ZW-1:0] z_in,
    input  logic [2*CW-1:0]      sq_in,
    input  logic [CW-1:0]        root_in,
    input  logic [CW+1:0]        rem_in,
    input  logic signed [CW-1:0] height_in,
    output prc_ctrl_t            ctrl_out,
    output logic signed [DW-1:0] x_out,
    output logic signed [DW-1:0] y_out,
    output logic signed [ZW-1:0] z_out,
    output logic [2*CW-1:0]      sq_out,
    output logic [CW-1:0]        root_out,
    output logic [CW+1:0]        rem_out,
    output logic signed [CW-1:0] height_out
);

    localparam logic signed [ZW-1:0] ATAN = {1'b0, atan_at(IDX)};

    prc_ctrl_t            ctrl_reg;
    logic signed [DW-1:0] x_reg,      x_next;
    logic signed [DW-1:0] y_reg,      y_next;
    logic signed [ZW-1:0] z_reg,      z_next;
    logic [2*CW-1:0]      sq_reg,     sq_next;
    logic [CW-1:0]        root_reg,   root_next;
    logic [CW+1:0]        rem_reg,    rem_next;
    logic signed [CW-1:0] height_reg;

    logic signed [DW-1:0] dx;
    logic signed [DW-1:0] dy;
    logic [CW+3:0]        cand;
    logic [CW+3:0]        trial;
    logic [CW+3:0]        diff;
    logic                 take;

    // micro-rotation: vectoring drives y to zero, rotation drives z to zero
    always_comb
    begin
        dx     = y_in >>> IDX;
        dy     = x_in >>> IDX;
        x_next = x_in;
        y_next = y_in;
        z_next = z_in;
        if (ROTATE)
        begin
            case (ctrl_in.cmd)
                CMD_TO_RECT:
                begin
                    if (!z_in[ZW-1])
                    begin
                        x_next = x_in - dx;
                        y_next = y_in + dy;
                        z_next = z_in - ATAN;
                    end
                    else
                    begin
                        x_next = x_in + dx;
                        y_next = y_in - dy;
                        z_next = z_in + ATAN;
                    end
                end
                default:
                begin
                    if (!y_in[DW-1])
                    begin
                        x_next = x_in + dx;
                        y_next = y_in - dy;
                        z_next = z_in + ATAN;
                    end
                    else
                    begin
                        x_next = x_in - dx;
                        y_next = y_in + dy;
                        z_next = z_in - ATAN;
                    end
                end
            endcase
        end
    end

    // restoring square root: one result bit from two operand bits
    always_comb
    begin
        cand      = {rem_in, sq_in[2*CW-1 -: 2]};
        trial     = {2'b00, root_in, 2'b01};
        diff      = cand - trial;
        take      = (cand >= trial);
        sq_next   = sq_in;
        root_next = root_in;
        rem_next  = rem_in;
        if (ROOT_STEP)
        begin
            sq_next   = {sq_in[2*CW-3:0], 2'b00};
            root_next = {root_in[CW-2:0], take};
            rem_next  = take ? diff[CW+1:0] : cand[CW+1:0];
        end
    end

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctrl_reg <= '0;
        end
        else if (pipe_en)
        begin
            ctrl_reg <= ctrl_in;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            x_reg      <= x_next;
            y_reg      <= y_next;
            z_reg      <= z_next;
            sq_reg     <= sq_next;
            root_reg   <= root_next;
            rem_reg    <= rem_next;
            height_reg <= height_in;
        end
    end

    assign ctrl_out   = ctrl_reg;
    assign x_out      = x_reg;
    assign y_out      = y_reg;
    assign z_out      = z_reg;
    assign sq_out     = sq_reg;
    assign root_out   = root_reg;
    assign rem_out    = rem_reg;
    assign height_out = height_reg;

endmodule

FILE: rtl/core/prc_post.sv
`timescale 1ns / 1ps
// result stage: radius rounding, angle rounding, coordinate saturation,
// output register with skid buffer; depends on prc_pkg
module prc_post import prc_pkg::*;
#(
    parameter int CW = COORD_WIDTH_DEF,
    parameter int DW = COORD_WIDTH_DEF + GUARD_BITS,
    parameter int TW = ((4 * COORD_WIDTH_DEF + ANGLE_WIDTH + 7) / 8) * 8
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 pipe_en,
    input  prc_ctrl_t            ctrl_in,
    input  logic signed [DW-1:0] x_in,
    input  logic signed [DW-1:0] y_in,
    input  logic signed [ZW-1:0] z_in,
    input  logic [CW-1:0]        root_in,
    input  logic [CW+1:0]        rem_in,
    input  logic signed [CW-1:0] height_in,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [TW-1:0]        m_tdata,
    output prc_stat_t            stat
);

    localparam int PW = 4 * CW + ANGLE_WIDTH;
    localparam int SW = DW - FRAC_BITS;
    localparam logic signed [SW-1:0] SAT_HI = {{(SW-CW+1){1'b0}}, {(CW-1){1'b1}}};
    localparam logic signed [SW-1:0] SAT_LO = {{(SW-CW+1){1'b1}}, {(CW-1){1'b0}}};
    localparam logic signed [DW-1:0] HALF_LSB = {{(DW-FRAC_BITS){1'b0}}, 1'b1,
                                                 {(FRAC_BITS-1){1'b0}}};

    logic                 out_valid_reg,  out_valid_next;
    logic [PW-1:0]        out_data_reg,   out_data_next;
    logic                 skid_valid_reg, skid_valid_next;
    logic [PW-1:0]        skid_data_reg,  skid_data_next;

    logic                 in_fire;
    logic [PW-1:0]        result;
    logic signed [DW-1:0] xr;
    logic signed [DW-1:0] yr;
    logic signed [SW-1:0] xs;
    logic signed [SW-1:0] ys;
    logic [CW-1:0]        sat_x;
    logic [CW-1:0]        sat_y;
    logic [CW-1:0]        rad;
    logic [31:0]          ang_sum;
    logic [CW-1:0]        res_x;
    logic [CW-1:0]        res_y;
    logic [CW-1:0]        res_rad;
    logic [ANGLE_WIDTH-1:0] res_ang;

    assign in_fire = ctrl_in.valid && pipe_en;

    // round and pack the result of the last cell
    always_comb
    begin
        xr      = x_in + HALF_LSB;
        yr      = y_in + HALF_LSB;
        xs      = xr[DW-1:FRAC_BITS];
        ys      = yr[DW-1:FRAC_BITS];
        sat_x   = (xs > SAT_HI) ? SAT_HI[CW-1:0] : ((xs < SAT_LO) ? SAT_LO[CW-1:0] : xs[CW-1:0]);
        sat_y   = (ys > SAT_HI) ? SAT_HI[CW-1:0] : ((ys < SAT_LO) ? SAT_LO[CW-1:0] : ys[CW-1:0]);
        rad     = (rem_in > {2'b00, root_in}) ? root_in + 1'b1 : root_in;
        ang_sum = z_in[31:0] + 32'h0000_8000;
        case (ctrl_in.cmd)
            CMD_TO_RECT:
            begin
                res_x   = sat_x;
                res_y   = sat_y;
                res_rad = '0;
                res_ang = '0;
            end
            default:
            begin
                res_x   = '0;
                res_y   = '0;
                res_rad = rad;
                res_ang = ctrl_in.origin ? '0 : ang_sum[31:16];
            end
        endcase
        result = {height_in, res_ang, res_rad, res_y, res_x};
    end

    // output register and skid buffer
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (!out_valid_reg || m_tready)
        begin
            if (skid_valid_reg)
            begin
                out_valid_next  = 1'b1;
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end
            else
            begin
                out_valid_next = in_fire;
                out_data_next  = result;
            end
        end
        else if (in_fire)
        begin
            skid_valid_next = 1'b1;
            skid_data_next  = result;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign m_tvalid        = out_valid_reg;
    assign m_tdata         = TW'(out_data_reg);
    assign stat.skid_valid = skid_valid_reg;

endmodule

FILE: bench/polar_rect_checker.sv
`timescale 1ns / 1ps
// watches both streams of the polar/rectangular converter, predicts each
// result from the accepted input and compares field by field; uses prc_pkg
module polar_rect_checker import prc_pkg::*;
#(
    parameter int TDATA_W = 80
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_tvalid,
    input  logic               s_tready,
    // coord_x, coord_y, radius, angle, height
    input  logic [TDATA_W-1:0] s_tdata,
    // cmd
    input  logic               s_tuser,
    input  logic               m_tvalid,
    input  logic               m_tready,
    // out_x, out_y, out_radius, out_angle, out_height
    input  logic [TDATA_W-1:0] m_tdata,
    output int                 mismatches,
    output int                 outstanding,
    output int                 polar_done,
    output int                 rect_done
);

    typedef struct packed
    {
        logic     [15:0] height;
        logic     [15:0] angle;
        logic     [15:0] radius;
        logic     [15:0] y;
        logic     [15:0] x;
        prc_cmd_t        cmd;
    } coord_result_t;

    // atan(2^-i) in units of 2^-32 turn, index 0 first
    localparam logic [0:15][31:0] ATAN_TURN = {
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
        32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
        32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D
    };
    localparam longint unsigned GAIN_Q30 = 64'd652032874;

    coord_result_t expected_q[$];
    int            err_count;
    int            polar_count;
    int            rect_count;

    // clamp to the signed 16-bit range
    function automatic logic [15:0] clamp16(input longint v);
        if (v > 32767)
            return 16'h7FFF;
        if (v < -32768)
            return 16'h8000;
        return v[15:0];
    endfunction

    // expected result of one conversion
    function automatic coord_result_t convert(input prc_cmd_t cmd, input logic [TDATA_W-1:0] d);
        coord_result_t   res;
        longint          x;
        longint          y;
        longint          dx;
        longint          dy;
        longint          acc;
        longint unsigned sq;
        longint unsigned rem;
        longint unsigned root;
        longint unsigned bitv;
        longint unsigned r;
        logic [31:0]     z;
        logic [31:0]     a;
        logic [32:0]     zr;
        res = '0;
        res.cmd = cmd;
        res.height = d[79:64];
        if (cmd == CMD_TO_POLAR)
        begin
            x = longint'($signed(d[15:0]));
            y = longint'($signed(d[31:16]));
            // square root rounded to nearest
            sq = longint'(x * x + y * y);
            rem = sq;
            root = 0;
            bitv = 64'h1 << 32;
            while (bitv > rem)
                bitv = bitv >> 2;
            while (bitv != 0)
            begin
                if (rem >= root + bitv)
                begin
                    rem = rem - (root + bitv);
                    root = (root >> 1) + bitv;
                end
                else
                    root = root >> 1;
                bitv = bitv >> 2;
            end
            if (sq - root * root > root)
                root = root + 1;
            res.radius = (root > 65535) ? 16'hFFFF : root[15:0];
            // vectoring cordic, left half plane folded over
            if (x != 0 || y != 0)
            begin
                z = 32'h0;
                if (x < 0)
                begin
                    x = -x;
                    y = -y;
                    z = 32'h80000000;
                end
                x = x * 65536;
                y = y * 65536;
                for (int i = 0; i < ITERATIONS_DEF; i++)
                begin
                    dx = y >>> i;
                    dy = x >>> i;
                    if (y >= 0)
                    begin
                        x = x + dx;
                        y = y - dy;
                        z = z + ATAN_TURN[i];
                    end
                    else
                    begin
                        x = x - dx;
                        y = y + dy;
                        z = z - ATAN_TURN[i];
                    end
                end
                zr = {1'b0, z} + 33'h8000;
                res.angle = zr[31:16];
            end
        end
        else
        begin
            // rotation cordic from the gain-compensated radius
            r = longint'(d[47:32]);
            x = longint'((r * GAIN_Q30) >> 14);
            y = 0;
            a = {d[63:48], 16'h0};
            if (a[31:30] == 2'b01 || a[31:30] == 2'b10)
            begin
                x = -x;
                a = a - 32'h80000000;
            end
            acc = longint'($signed(a));
            for (int i = 0; i < ITERATIONS_DEF; i++)
            begin
                dx = y >>> i;
                dy = x >>> i;
                if (acc >= 0)
                begin
                    x = x - dx;
                    y = y + dy;
                    acc = acc - longint'(ATAN_TURN[i]);
                end
                else
                begin
                    x = x + dx;
                    y = y - dy;
                    acc = acc + longint'(ATAN_TURN[i]);
                end
            end
            res.x = clamp16((x + 32768) >>> 16);
            res.y = clamp16((y + 32768) >>> 16);
        end
        return res;
    endfunction

    task automatic check_field(input string name, input int want, input int got);
        if (want != got)
        begin
            err_count++;
            $display("%0t ns: %s mismatch, expected %0d actual %0d", $time, name, want, got);
        end
    endtask

    // result side first, so a result arriving with no prior input is flagged
    always @(posedge clk)
    begin
        coord_result_t want;
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                if (expected_q.size() == 0)
                begin
                    err_count++;
                    $display("%0t ns: result transaction with none expected, actual %h",
                             $time, m_tdata);
                end
                else
                begin
                    want = expected_q.pop_front();
                    check_field("out_x", int'($signed(want.x)), int'($signed(m_tdata[15:0])));
                    check_field("out_y", int'($signed(want.y)), int'($signed(m_tdata[31:16])));
                    check_field("out_radius", int'(want.radius), int'(m_tdata[47:32]));
                    check_field("out_angle", int'(want.angle), int'(m_tdata[63:48]));
                    check_field("out_height", int'($signed(want.height)),
                                int'($signed(m_tdata[79:64])));
                    if (want.cmd == CMD_TO_POLAR)
                        polar_count++;
                    else
                        rect_count++;
                end
            end
            if (s_tvalid && s_tready)
                expected_q.push_back(convert(prc_cmd_t'(s_tuser), s_tdata));
        end
        mismatches  <= err_count;
        outstanding <= expected_q.size();
        polar_done  <= polar_count;
        rect_done   <= rect_count;
    end

endmodule

FILE: bench/tb.sv
`timescale 1ns / 1ps
// top of the converter bench: clock, reset, stimulus in three pacing phases
// and the verdict; needs prc_pkg, polar_rect_converter_unit, polar_rect_checker
module tb import prc_pkg::*;
();

    localparam int TDATA_W          = ((4*COORD_WIDTH_DEF+ANGLE_WIDTH+7)/8)*8;
    localparam int RANDOM_PER_PHASE = 370;
    localparam int HOLD_CYCLES      = 300;
    localparam int DRAIN_CYCLES     = 40;
    localparam int CYCLE_LIMIT      = 200000;

    logic               clk = 1'b0;
    logic               rst_n;
    logic               s_tvalid;
    logic               s_tready;
    logic [TDATA_W-1:0] s_tdata;
    logic               s_tuser;
    logic               m_tvalid;
    logic               m_tready;
    logic [TDATA_W-1:0] m_tdata;

    int mismatches;
    int outstanding;
    int polar_done;
    int rect_done;
    int send_idle;
    int recv_idle;
    int cycle_count;
    bit hold_armed;
    bit hold_done;

    always #6 clk = ~clk;

    polar_rect_converter_unit DUT
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    polar_rect_checker #(.TDATA_W(TDATA_W)) u_checker
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .mismatches  (mismatches),
        .outstanding (outstanding),
        .polar_done  (polar_done),
        .rect_done   (rect_done)
    );

    // offer one transaction after random idle cycles, return at the next falling edge
    task automatic send_item(input prc_cmd_t cmd, input logic [15:0] fx, input logic [15:0] fy,
                             input logic [15:0] fr, input logic [15:0] fa,
                             input logic [15:0] fh);
        while ($urandom_range(99) < send_idle)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {fh, fa, fr, fy, fx};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        @(negedge clk);
    endtask

    function automatic logic [15:0] pick_corner();
        case ($urandom_range(5))
            0:       return 16'h8000;
            1:       return 16'h8001;
            2:       return 16'hFFFF;
            3:       return 16'h0000;
            4:       return 16'h0001;
            default: return 16'h7FFF;
        endcase
    endfunction

    // random item: mostly full-range values, some tiny vectors, corners and angles near quadrant boundaries
    task automatic send_random();
        int          kind;
        int          tmp;
        logic [15:0] fx;
        logic [15:0] fy;
        logic [15:0] fr;
        logic [15:0] fa;
        logic [15:0] fh;
        prc_cmd_t    cmd;
        kind = $urandom_range(9);
        fx   = 16'($urandom_range(65535));
        fy   = 16'($urandom_range(65535));
        fr   = 16'($urandom_range(65535));
        fa   = 16'($urandom_range(65535));
        fh   = 16'($urandom_range(65535));
        cmd  = (kind < 6) ? CMD_TO_POLAR : CMD_TO_RECT;
        if (kind == 4)
        begin
            tmp = $urandom_range(8);
            fx  = 16'(tmp - 4);
            tmp = $urandom_range(8);
            fy  = 16'(tmp - 4);
        end
        else if (kind == 5)
        begin
            fx = pick_corner();
            fy = pick_corner();
        end
        else if (kind == 9)
        begin
            // near quadrant boundaries, large or tiny radius
            tmp = $urandom_range(6);
            fa  = 16'(($urandom_range(3) << 14) + tmp - 3);
            fr  = 16'(($urandom_range(1) != 0) ? 65535 - $urandom_range(15)
                                                : $urandom_range(3));
        end
        send_item(cmd, fx, fy, fr, fa, fh);
    endtask

    // receiver pacing, with one long hold-off when armed
    initial
    begin
        m_tready  = 1'b0;
        hold_done = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_armed && !hold_done)
            begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES - 1)
                    @(negedge clk);
                hold_done = 1'b1;
            end
            else
                m_tready <= ($urandom_range(99) >= recv_idle);
        end
    end

    // run limit
    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles", cycle_count);
        $display("Regression FAIL");
        $finish;
    end

    // stimulus and verdict
    initial
    begin
        rst_n      = 1'b0;
        s_tvalid   = 1'b0;
        s_tuser    = 1'b0;
        s_tdata    = '0;
        send_idle  = 9;
        recv_idle  = 48;
        hold_armed = 1'b0;
        repeat (9)
            @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // rectangular to polar: origin, axes, extremes, left half plane
        send_item(CMD_TO_POLAR, 16'h0000, 16'h0000, 16'h1234, 16'h5678, 16'h0000);
        send_item(CMD_TO_POLAR, 16'h7FFF, 16'h0000, 16'hFFFF, 16'hFFFF, 16'h7FFF);
        send_item(CMD_TO_POLAR, 16'h8000, 16'h0000, 16'h0000, 16'h0000, 16'h8000);
        send_item(CMD_TO_POLAR, 16'h0000, 16'h7FFF, 16'hAAAA, 16'h5555, 16'hFFFF);
        send_item(CMD_TO_POLAR, 16'h0000, 16'h8000, 16'h5555, 16'hAAAA, 16'h0001);
        send_item(CMD_TO_POLAR, 16'h8000, 16'h8000, 16'h0000, 16'h0000, 16'h1234);
        send_item(CMD_TO_POLAR, 16'h7FFF, 16'h7FFF, 16'h0000, 16'h0000, 16'hEDCB);
        send_item(CMD_TO_POLAR, 16'hFFFF, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
        send_item(CMD_TO_POLAR, 16'hFFFF, 16'hFFFF, 16'h0000, 16'h0000, 16'h0000);
        send_item(CMD_TO_POLAR, 16'h0001, 16'hFFFF, 16'h0000, 16'h0000, 16'h0000);
        send_item(CMD_TO_POLAR, 16'h8000, 16'h0001, 16'h0000, 16'h0000, 16'h0000);
        send_item(CMD_TO_POLAR, 16'h8000, 16'h7FFF, 16'h0000, 16'h0000, 16'h0000);
        send_item(CMD_TO_POLAR, 16'h0003, 16'h0004, 16'h0000, 16'h0000, 16'h0000);
        // polar to rectangular: zero radius, quadrant starts, saturation
        send_item(CMD_TO_RECT, 16'h1111, 16'h2222, 16'h0000, 16'h1234, 16'h7FFF);
        send_item(CMD_TO_RECT, 16'h0000, 16'h0000, 16'hFFFF, 16'h0000, 16'h8000);
        send_item(CMD_TO_RECT, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h4000, 16'h0000);
        send_item(CMD_TO_RECT, 16'h0000, 16'h0000, 16'hFFFF, 16'h8000, 16'h0000);
        send_item(CMD_TO_RECT, 16'h0000, 16'h0000, 16'hFFFF, 16'hC000, 16'h0000);
        send_item(CMD_TO_RECT, 16'h0000, 16'h0000, 16'hFFFF, 16'hFFFF, 16'h0000);
        send_item(CMD_TO_RECT, 16'h0000, 16'h0000, 16'hFFFF, 16'h3FFF, 16'h0000);
        send_item(CMD_TO_RECT, 16'h0000, 16'h0000, 16'hFFFF, 16'h2000, 16'h0000);
        send_item(CMD_TO_RECT, 16'h0000, 16'h0000, 16'hFFFF, 16'h6000, 16'h0000);
        send_item(CMD_TO_RECT, 16'h0000, 16'h0000, 16'hFFFF, 16'hBFFF, 16'h0000);
        send_item(CMD_TO_RECT, 16'h0000, 16'h0000, 16'h0001, 16'h0000, 16'h0000);
        send_item(CMD_TO_RECT, 16'h0000, 16'h0000, 16'h8000, 16'hE000, 16'h0000);

        // random, slow receiver
        for (int n = 0; n < RANDOM_PER_PHASE; n++)
            send_random();
        // random, slow sender
        send_idle = 48;
        recv_idle = 9;
        for (int n = 0; n < RANDOM_PER_PHASE; n++)
            send_random();
        // random, full rate with one long output stall to back up the pipeline
        send_idle  = 0;
        recv_idle  = 0;
        hold_armed = 1'b1;
        for (int n = 0; n < RANDOM_PER_PHASE; n++)
            send_random();
        s_tvalid <= 1'b0;

        // drain
        while (outstanding != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES)
            @(posedge clk);

        $display("checked %0d to-polar and %0d to-rect transactions over three pacing phases",
                 polar_done, rect_done);
        $display("including a %0d-cycle output stall at full input rate", HOLD_CYCLES);
        if (mismatches == 0 && outstanding == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
